// File: design/rlzd_pkg.sv
package rlzd_pkg;

    // fixed geometry of the decoder
    localparam int HISTORY_DEPTH = 1024;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int LENGTH_BITS   = 24;
    localparam int SEQ_DEPTH     = 65;
    localparam int SEQ_AW        = $clog2(SEQ_DEPTH);
    localparam int RUN_W         = 14;
    localparam int REP_W         = 9;
    localparam int DIST_W        = 11;
    localparam int TDATA_W       = 16;
    localparam int CFG_IDX_W     = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_LENGTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LENGTH = 1'd1;

    // decoder phase
    typedef enum logic [3:0] {
        PH_OP       = 4'd0,
        PH_RB_EXT   = 4'd1,
        PH_RB_DATA  = 4'd2,
        PH_RB_EMIT  = 4'd3,
        PH_BR_DIST  = 4'd4,
        PH_BR_EMIT  = 4'd5,
        PH_MS_COUNT = 4'd6,
        PH_MS_LOAD  = 4'd7,
        PH_MS_EMIT  = 4'd8,
        PH_LIT_EXT  = 4'd9,
        PH_LIT_DATA = 4'd10
    } t_phase;

    // where an emitted byte comes from
    typedef enum logic [1:0] {
        SRC_DIRECT = 2'd0,
        SRC_HIST   = 2'd1,
        SRC_SEQ    = 2'd2
    } t_src;

    // one decoded step, handed from the control to the memory stage
    typedef struct packed {
        logic               consumed;
        logic               emit;
        t_src               src;
        logic [7:0]         data;
        logic [HIST_AW-1:0] hist_raddr;
        logic [HIST_AW-1:0] hist_waddr;
        logic [SEQ_AW-1:0]  seq_raddr;
        logic               seq_we;
        logic [SEQ_AW-1:0]  seq_waddr;
        logic               finished;
        logic               failed;
    } t_step;

endpackage

// File: design/rlzd_ctrl.sv
module rlzd_ctrl #(
    parameter int LENGTH_BITS = rlzd_pkg::LENGTH_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic                            i_in_valid,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_cfg_we,
    input  logic [rlzd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [LENGTH_BITS-1:0]          i_cfg_data,
    output rlzd_pkg::t_step                 o_step
);
    import rlzd_pkg::*;

    localparam int LB = LENGTH_BITS;

    t_phase            r_phase, n_phase;
    logic [RUN_W-1:0]  r_run, n_run;
    logic [REP_W-1:0]  r_rep, n_rep;
    logic [SEQ_AW-1:0] r_sidx, n_sidx;
    logic [SEQ_AW-1:0] r_slen, n_slen;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic [7:0]        r_fill, n_fill;
    logic [1:0]        r_op_lo, n_op_lo;
    logic [LB-1:0]     r_wr, n_wr;
    logic [LB-1:0]     r_rd, n_rd;
    logic              r_err, n_err;
    logic [LB-1:0]     r_in_len;
    logic [LB-1:0]     r_out_len;

    logic [LB-1:0]     in_left, in_left_after, out_left;
    logic              active, need_in, take_ok, starve, emit_phase, do_emit;
    logic [RUN_W-1:0]  run_ext, run_dec;
    logic [LB-1:0]     run_ext_w, run_w, run_lit_w;
    logic [RUN_W-1:0]  run_lit;
    logic [DIST_W-1:0] dist_new;
    logic [SEQ_AW-1:0] sidx_inc;

    // bytes left on either side, saturating at zero
    assign in_left       = (r_in_len > r_rd) ? (r_in_len - r_rd) : '0;
    assign in_left_after = in_left - 1'b1;
    assign out_left      = (r_out_len > r_wr) ? (r_out_len - r_wr) : '0;

    assign active     = !r_err && (r_wr < r_out_len);
    assign emit_phase = (r_phase == PH_RB_EMIT) || (r_phase == PH_BR_EMIT)
                     || (r_phase == PH_MS_EMIT);
    assign need_in    = !emit_phase && (r_phase <= PH_LIT_DATA);
    assign starve     = active && need_in && (in_left == '0);
    assign take_ok    = active && need_in && (in_left != '0) && i_in_valid;
    assign do_emit    = (active && emit_phase) || (take_ok && r_phase == PH_LIT_DATA);

    // run arithmetic shared by several phases
    assign run_ext   = r_run + {1'b0, i_in_byte, 5'b0};
    assign run_dec   = r_run - 1'b1;
    assign run_lit   = RUN_W'(i_in_byte[4:0]) + 1'b1;
    assign run_ext_w = {{(LB-RUN_W){1'b0}}, run_ext};
    assign run_w     = {{(LB-RUN_W){1'b0}}, r_run};
    assign run_lit_w = {{(LB-RUN_W){1'b0}}, run_lit};
    assign dist_new  = {1'b0, r_op_lo, i_in_byte} + 1'b1;
    assign sidx_inc  = r_sidx + 1'b1;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_run   = r_run;
        n_rep   = r_rep;
        n_sidx  = r_sidx;
        n_slen  = r_slen;
        n_dist  = r_dist;
        n_fill  = r_fill;
        n_op_lo = r_op_lo;
        n_wr    = do_emit ? (r_wr + 1'b1) : r_wr;
        n_rd    = take_ok ? (r_rd + 1'b1) : r_rd;
        n_err   = r_err || starve;
        if (active) begin
            unique case (r_phase)
                PH_OP: if (take_ok) begin
                    n_op_lo = i_in_byte[1:0];
                    if (in_left_after == '0) begin
                        n_err = 1'b1;
                    end else if (i_in_byte[7] && i_in_byte[6]) begin
                        n_run   = RUN_W'(i_in_byte[4:0]) + 2'd2;
                        n_phase = i_in_byte[5] ? PH_RB_EXT : PH_RB_DATA;
                    end else if (i_in_byte[7]) begin
                        n_run   = RUN_W'(i_in_byte[5:2]) + 2'd2;
                        n_phase = PH_BR_DIST;
                    end else if (i_in_byte[6]) begin
                        n_slen  = SEQ_AW'(i_in_byte[5:0]) + 2'd2;
                        n_phase = PH_MS_COUNT;
                    end else begin
                        n_run = run_lit;
                        if (i_in_byte[5]) begin
                            n_phase = PH_LIT_EXT;
                        end else if (run_lit_w > in_left_after || run_lit_w > out_left) begin
                            n_err = 1'b1;
                        end else begin
                            n_phase = PH_LIT_DATA;
                        end
                    end
                end
                PH_RB_EXT: if (take_ok) begin
                    n_run = run_ext;
                    if (in_left_after == '0) n_err = 1'b1;
                    else n_phase = PH_RB_DATA;
                end
                PH_RB_DATA: if (take_ok) begin
                    n_fill = i_in_byte;
                    if (run_w > out_left) n_err = 1'b1;
                    else n_phase = PH_RB_EMIT;
                end
                PH_BR_DIST: if (take_ok) begin
                    n_dist = dist_new;
                    if ({{(LB-DIST_W){1'b0}}, dist_new} > r_wr || run_w > out_left) begin
                        n_err = 1'b1;
                    end else begin
                        n_phase = PH_BR_EMIT;
                    end
                end
                PH_MS_COUNT: if (take_ok) begin
                    n_rep  = REP_W'(i_in_byte) + 1'b1;
                    n_sidx = '0;
                    if (in_left_after < {{(LB-SEQ_AW){1'b0}}, r_slen}) n_err = 1'b1;
                    else n_phase = PH_MS_LOAD;
                end
                PH_MS_LOAD: if (take_ok) begin
                    n_sidx = sidx_inc;
                    if (sidx_inc >= r_slen) begin
                        n_sidx  = '0;
                        n_phase = PH_MS_EMIT;
                    end
                end
                PH_MS_EMIT: begin
                    n_sidx = sidx_inc;
                    if (sidx_inc >= r_slen) begin
                        n_sidx = '0;
                        n_rep  = r_rep - 1'b1;
                        if (r_rep == REP_W'(1)) n_phase = PH_OP;
                    end
                end
                PH_LIT_EXT: if (take_ok) begin
                    n_run = run_ext;
                    if (run_ext_w > in_left_after || run_ext_w > out_left) n_err = 1'b1;
                    else n_phase = PH_LIT_DATA;
                end
                PH_RB_EMIT, PH_BR_EMIT, PH_LIT_DATA: if (do_emit) begin
                    n_run = run_dec;
                    if (run_dec == '0) n_phase = PH_OP;
                end
                default: n_phase = PH_OP;
            endcase
        end
    end

    // step outputs
    always_comb begin
        o_step            = '0;
        o_step.consumed   = take_ok;
        o_step.emit       = do_emit;
        o_step.data       = (r_phase == PH_RB_EMIT) ? r_fill : i_in_byte;
        o_step.hist_raddr = r_wr[HIST_AW-1:0] - r_dist[HIST_AW-1:0];
        o_step.hist_waddr = r_wr[HIST_AW-1:0];
        o_step.seq_raddr  = r_sidx;
        o_step.seq_we     = take_ok && (r_phase == PH_MS_LOAD);
        o_step.seq_waddr  = r_sidx;
        o_step.finished   = (n_wr >= r_out_len);
        o_step.failed     = n_err;
        if (r_phase == PH_BR_EMIT) o_step.src = SRC_HIST;
        else if (r_phase == PH_MS_EMIT) o_step.src = SRC_SEQ;
        else o_step.src = SRC_DIRECT;
    end

    // state registers, updated once per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_OP;
            r_run     <= '0;
            r_rep     <= '0;
            r_sidx    <= '0;
            r_slen    <= '0;
            r_dist    <= '0;
            r_fill    <= '0;
            r_op_lo   <= '0;
            r_wr      <= '0;
            r_rd      <= '0;
            r_err     <= 1'b0;
            r_in_len  <= '0;
            r_out_len <= '0;
        end else begin
            if (i_step) begin
                r_phase <= n_phase;
                r_run   <= n_run;
                r_rep   <= n_rep;
                r_sidx  <= n_sidx;
                r_slen  <= n_slen;
                r_dist  <= n_dist;
                r_fill  <= n_fill;
                r_op_lo <= n_op_lo;
                r_wr    <= n_wr;
                r_rd    <= n_rd;
                r_err   <= n_err;
            end
            if (i_cfg_we && i_cfg_idx == REG_INPUT_LENGTH) r_in_len <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == REG_OUTPUT_LENGTH) r_out_len <= i_cfg_data;
        end
    end

endmodule

// File: design/rle_lz_byte_decompressor.sv
// Byte decompressor for a mixed run-length / back-reference code. Each input
// word is one decoder step and yields exactly one output word, one per clock
// when neither side stalls. A step decodes all control state in its accept
// cycle and issues reads of the 1024-byte history and the 65-byte sequence
// buffer; the byte is picked from the registered read data in the memory stage
// and written back to the history as that stage advances, with a bypass when
// the very next step reads that entry. The output register follows that stage.
module rle_lz_byte_decompressor #(
    parameter int LENGTH_BITS = rlzd_pkg::LENGTH_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // bit 0 in_valid, bits 8:1 in_byte
    input  logic [rlzd_pkg::TDATA_W-1:0]    i_s_axis_tdata,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // bit 0 consumed, bit 1 out_valid, bits 9:2 out_byte, bit 10 finished,
    // bit 11 failed
    output logic [rlzd_pkg::TDATA_W-1:0]    o_m_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rlzd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [LENGTH_BITS-1:0]          i_cfg_data
);
    import rlzd_pkg::*;

    t_step             step;
    t_step             r_p;
    logic              r_p_valid;
    logic              r_p_fwd;
    logic [7:0]        r_hist_q;
    logic [7:0]        r_seq_q;
    logic [7:0]        r_last_byte;
    logic              r_o_valid;
    logic [TDATA_W-1:0] r_o_data;
    logic [7:0]        hist_mem [HISTORY_DEPTH];
    logic [7:0]        seq_mem  [SEQ_DEPTH];
    logic              accept, advance;
    logic [7:0]        p_byte;

    // handshakes
    assign advance         = r_p_valid && (!r_o_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_p_valid || advance;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    rlzd_ctrl #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (accept),
        .i_in_valid (i_s_axis_tdata[0]),
        .i_in_byte  (i_s_axis_tdata[8:1]),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_step     (step)
    );

    // history and sequence buffer reads, issued on accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hist_q <= hist_mem[step.hist_raddr];
            r_seq_q  <= seq_mem[step.seq_raddr];
        end
    end

    // sequence buffer load straight from the input word
    always_ff @(posedge i_clk) begin
        if (accept && step.seq_we) seq_mem[step.seq_waddr] <= step.data;
    end

    // byte select in the memory stage, with bypass of the byte being written
    always_comb begin
        unique case (r_p.src)
            SRC_HIST: p_byte = r_p_fwd ? r_last_byte : r_hist_q;
            SRC_SEQ:  p_byte = r_seq_q;
            default:  p_byte = r_p.data;
        endcase
    end

    // history write-back
    always_ff @(posedge i_clk) begin
        if (advance && r_p.emit) begin
            hist_mem[r_p.hist_waddr] <= p_byte;
            r_last_byte              <= p_byte;
        end
    end

    // memory stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (accept) begin
            r_p_valid <= 1'b1;
        end else if (advance) begin
            r_p_valid <= 1'b0;
        end
    end

    // bypass only for a history copy that reads the entry written this cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p     <= step;
            r_p_fwd <= advance && r_p.emit && (step.src == SRC_HIST)
                    && (r_p.hist_waddr == step.hist_raddr);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_data <= {4'b0, r_p.failed, r_p.finished,
                         (r_p.emit ? p_byte : 8'd0), r_p.emit, r_p.consumed};
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;

`ifndef SYNTHESIS
    // a new word never lands on a stage that still holds one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_p_valid |-> advance)
        else $error("memory stage overwritten");

    // the bypass only serves history copies
    a_fwd_hist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid && r_p_fwd |-> r_p.src == SRC_HIST)
        else $error("bypass on non-history byte");

    // once failure is reported, every later word reports it
    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_data[11] && advance |=> r_o_data[11])
        else $error("failure flag cleared");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rlzd_pkg::*;

    localparam int LIMIT      = 2_000_000;
    localparam int RAND_STEPS = 2000;
    localparam int HOLD_LEN   = 400;

    // opcode classes, top two bits of an opcode byte
    localparam logic [1:0] OPC_LITERAL = 2'b00;
    localparam logic [1:0] OPC_SEQ     = 2'b01;
    localparam logic [1:0] OPC_COPY    = 2'b10;
    localparam logic [1:0] OPC_FILL    = 2'b11;

    // ways to end the run with a sticky failure
    localparam int FAIL_EXHAUSTED = 0;
    localparam int FAIL_TOO_LONG  = 1;
    localparam int FAIL_SHORT_SEQ = 2;

    // one output word, split into its fields
    typedef struct packed {
        logic       consumed;
        logic       out_valid;
        logic [7:0] out_byte;
        logic       finished;
        logic       failed;
    } t_dec_word;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_in_row;

    localparam t_dec_word IDLE_DONE_WORD = '{1'b0, 1'b0, 8'h00, 1'b1, 1'b0};

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic [TDATA_W-1:0]   s_data    = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [TDATA_W-1:0]   m_data;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = REG_INPUT_LENGTH;
    logic [23:0]          cfg_data  = '0;
    logic                 cfg_ready;

    rle_lz_byte_decompressor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder shadow state
    logic [23:0] in_len = '0;
    logic [23:0] out_len = '0;
    logic [23:0] n_wr = '0;
    logic [23:0] n_rd = '0;
    logic [7:0]  hist [HISTORY_DEPTH];
    logic [7:0]  seq_buf [SEQ_DEPTH];
    t_phase      ph = PH_OP;
    logic [RUN_W-1:0]  run = '0;
    logic [REP_W-1:0]  reps = '0;
    logic [6:0]        sidx = '0;
    logic [6:0]        slen = '0;
    logic [DIST_W-1:0] copy_dist = '0;
    logic [7:0]        fill = '0;
    logic [7:0]        cur_op = '0;
    bit                err = 1'b0;
    bit                st_cons;
    bit                st_emit;
    logic [7:0]        st_byte;

    t_dec_word   pending_words [$];
    logic [7:0]  comp [$];
    int          plain_len;
    int          fails = 0;
    int          n_steps = 0;
    int          burst_left = 0;
    int          cycles = 0;
    bit          hold_req = 1'b0;
    t_dec_word   got;

    function automatic logic [23:0] in_room();
        return (in_len > n_rd) ? in_len - n_rd : 24'd0;
    endfunction

    function automatic logic [23:0] out_room();
        return (out_len > n_wr) ? out_len - n_wr : 24'd0;
    endfunction

    function automatic bit grab(bit v, logic [7:0] b, output logic [7:0] got_b);
        got_b = b;
        if (in_room() == 0) begin
            err = 1'b1;
            return 1'b0;
        end
        if (!v) return 1'b0;
        n_rd++;
        st_cons = 1'b1;
        return 1'b1;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        hist[n_wr[HIST_AW-1:0]] = b;
        n_wr++;
        st_emit = 1'b1;
        st_byte = b;
    endfunction

    function automatic void run_step();
        run = run - 1'b1;
        if (run == 0) ph = PH_OP;
    endfunction

    function automatic void start_op(logic [7:0] x);
        cur_op = x;
        case (x[7:6])
            OPC_FILL: begin
                run = RUN_W'(x[4:0]) + RUN_W'(2);
                ph = x[5] ? PH_RB_EXT : PH_RB_DATA;
            end
            OPC_COPY: begin
                run = RUN_W'(x[5:2]) + RUN_W'(2);
                ph = PH_BR_DIST;
            end
            OPC_SEQ: begin
                slen = 7'(x[5:0]) + 7'd2;
                ph = PH_MS_COUNT;
            end
            default: begin
                run = RUN_W'(x[4:0]) + RUN_W'(1);
                if (x[5]) ph = PH_LIT_EXT;
                else if (24'(run) > in_room() || 24'(run) > out_room()) err = 1'b1;
                else ph = PH_LIT_DATA;
            end
        endcase
    endfunction

    // one decoder step for one accepted input word
    function automatic t_dec_word decode_step(bit v, logic [7:0] b);
        logic [7:0] x;
        t_dec_word  w;
        st_cons = 1'b0;
        st_emit = 1'b0;
        st_byte = 8'h00;
        if (!err && n_wr < out_len) begin
            case (ph)
                PH_OP: if (grab(v, b, x)) begin
                    if (in_room() == 0) err = 1'b1;
                    else start_op(x);
                end
                PH_RB_EXT: if (grab(v, b, x)) begin
                    run = run + {x, 5'd0};
                    if (in_room() == 0) err = 1'b1;
                    else ph = PH_RB_DATA;
                end
                PH_RB_DATA: if (grab(v, b, x)) begin
                    fill = x;
                    if (24'(run) > out_room()) err = 1'b1;
                    else ph = PH_RB_EMIT;
                end
                PH_RB_EMIT: begin
                    put_byte(fill);
                    run_step();
                end
                PH_BR_DIST: if (grab(v, b, x)) begin
                    copy_dist = DIST_W'({cur_op[1:0], x}) + DIST_W'(1);
                    if (24'(copy_dist) > n_wr || 24'(run) > out_room()) err = 1'b1;
                    else ph = PH_BR_EMIT;
                end
                PH_BR_EMIT: begin
                    put_byte(hist[HIST_AW'(n_wr - 24'(copy_dist))]);
                    run_step();
                end
                PH_MS_COUNT: if (grab(v, b, x)) begin
                    reps = REP_W'(x) + REP_W'(1);
                    sidx = '0;
                    if (in_room() < 24'(slen)) err = 1'b1;
                    else ph = PH_MS_LOAD;
                end
                PH_MS_LOAD: if (grab(v, b, x)) begin
                    seq_buf[sidx] = x;
                    sidx++;
                    if (sidx >= slen) begin
                        sidx = '0;
                        ph = PH_MS_EMIT;
                    end
                end
                PH_MS_EMIT: begin
                    put_byte(seq_buf[sidx]);
                    sidx++;
                    if (sidx >= slen) begin
                        sidx = '0;
                        reps = reps - 1'b1;
                        if (reps == 0) ph = PH_OP;
                    end
                end
                PH_LIT_EXT: if (grab(v, b, x)) begin
                    run = run + {x, 5'd0};
                    if (24'(run) > in_room() || 24'(run) > out_room()) err = 1'b1;
                    else ph = PH_LIT_DATA;
                end
                PH_LIT_DATA: if (grab(v, b, x)) begin
                    put_byte(x);
                    run_step();
                end
                default: ph = PH_OP;
            endcase
        end
        w.consumed  = st_cons;
        w.out_valid = st_emit;
        w.out_byte  = st_emit ? st_byte : 8'h00;
        w.finished  = (n_wr >= out_len);
        w.failed    = err;
        return w;
    endfunction

    // offer one word, with random gaps between bursts
    task automatic offer(input bit v, input logic [7:0] b, input bit fixed,
                         input t_dec_word fixed_w, output bit took);
        int        gap;
        t_dec_word w;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_valid <= 1'b1;
        s_data  <= {7'd0, b, v};
        do @(posedge i_clk); while (!s_ready);
        w = decode_step(v, b);
        took = w.consumed;
        pending_words.push_back(fixed ? fixed_w : w);
        burst_left--;
        n_steps++;
    endtask

    task automatic quiet();
        s_valid <= 1'b0;
        burst_left = 0;
    endtask

    // wait for the block to drain before touching registers
    task automatic settle();
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        if (last) cfg_valid <= 1'b0;
        if (idx == REG_INPUT_LENGTH) in_len = val;
        else out_len = val;
    endtask

    task automatic set_lengths(input logic [23:0] il, input logic [23:0] ol);
        write_reg(REG_INPUT_LENGTH, il, 1'b0);
        write_reg(REG_OUTPUT_LENGTH, ol, 1'b1);
    endtask

    // build a well-formed compressed run of n_ops operations
    task automatic build_stream(input int n_ops);
        int         k;
        int         len;
        int         e;
        int         maxd;
        int         d;
        logic [7:0] op;
        comp.delete();
        plain_len = 0;
        for (int i = 0; i < n_ops; i++) begin
            maxd = int'(n_wr) + plain_len;
            if (maxd > HISTORY_DEPTH) maxd = HISTORY_DEPTH;
            k = $urandom_range(0, 3);
            case (k)
                0: begin
                    op = {OPC_FILL, 1'b0, 5'($urandom_range(0, 31))};
                    op[5] = ($urandom_range(0, 5) == 0);
                    comp.push_back(op);
                    len = int'(op[4:0]) + 2;
                    if (op[5]) begin
                        e = ($urandom_range(0, 199) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 3);
                        comp.push_back(8'(e));
                        len += e * 32;
                    end
                    comp.push_back(8'($urandom));
                    plain_len += len;
                end
                1: begin
                    d = $urandom_range(1, maxd);
                    op = {OPC_COPY, 4'($urandom_range(0, 15)), 2'((d - 1) >> 8)};
                    comp.push_back(op);
                    comp.push_back(8'(d - 1));
                    plain_len += int'(op[5:2]) + 2;
                end
                2: begin
                    len = $urandom_range(2, 65);
                    e = ($urandom_range(0, 199) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 3);
                    comp.push_back({OPC_SEQ, 6'(len - 2)});
                    comp.push_back(8'(e));
                    repeat (len) comp.push_back(8'($urandom));
                    plain_len += len * (e + 1);
                end
                default: begin
                    op = {OPC_LITERAL, 1'b0, 5'($urandom_range(0, 31))};
                    op[5] = ($urandom_range(0, 3) == 0);
                    comp.push_back(op);
                    len = int'(op[4:0]) + 1;
                    if (op[5]) begin
                        e = $urandom_range(0, 1);
                        comp.push_back(8'(e));
                        len += e * 32;
                    end
                    repeat (len) comp.push_back(8'($urandom));
                    plain_len += len;
                end
            endcase
        end
    endtask

    // walk comp until the output budget is met, or until failure
    task automatic feed(input bit to_failure);
        int         ptr;
        bit         v;
        bit         took;
        logic [7:0] b;
        ptr = 0;
        while (to_failure ? !err : (n_wr < out_len && !err)) begin
            v = ($urandom_range(0, 9) != 0);
            b = (ptr < comp.size()) ? comp[ptr] : 8'($urandom);
            offer(v, b, 1'b0, '0, took);
            if (took) ptr++;
        end
        quiet();
    endtask

    // directed stream: literal, fill, overlapping copy, sequence, extended forms
    t_in_row dir_rows [19] = '{
        '{1'b1, 8'h00}, '{1'b1, 8'hFF},
        '{1'b1, 8'hC0}, '{1'b1, 8'h00},
        '{1'b0, 8'hFF},
        '{1'b1, 8'h80}, '{1'b1, 8'h00},
        '{1'b1, 8'h40}, '{1'b1, 8'h01}, '{1'b1, 8'hA5}, '{1'b1, 8'h5A},
        '{1'b1, 8'hE0}, '{1'b1, 8'h00}, '{1'b1, 8'h3C},
        '{1'b1, 8'h20}, '{1'b1, 8'h00}, '{1'b1, 8'h81},
        '{1'b1, 8'h8C}, '{1'b1, 8'h0B}
    };
    localparam int DIR_IN_BYTES = 18;
    localparam int DIR_OUT      = 17;

    initial begin
        int         idx;
        int         kind;
        int         left;
        int         len;
        int         e;
        bit         took;
        for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] = 8'h00;
        for (int i = 0; i < SEQ_DEPTH; i++) seq_buf[i] = 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero output length: done at once, nothing taken
        set_lengths(24'd0, 24'd0);
        for (int i = 0; i < 3; i++) offer(1'b1, 8'hC0, 1'b1, IDLE_DONE_WORD, took);
        quiet();
        settle();

        set_lengths(n_rd + 24'(DIR_IN_BYTES), n_wr + 24'(DIR_OUT));
        idx = 0;
        while (idx < 19 || (n_wr < out_len && !err)) begin
            if (idx < 19) begin
                offer(dir_rows[idx].valid, dir_rows[idx].data, 1'b0, '0, took);
                if (took || !dir_rows[idx].valid) idx++;
            end else begin
                offer(1'b0, 8'($urandom), 1'b0, '0, took);
            end
        end
        quiet();
        settle();

        // random well-formed runs
        hold_req = 1'b1;
        idx = n_steps;
        while (n_steps < idx + RAND_STEPS) begin
            build_stream($urandom_range(1, 6));
            set_lengths(n_rd + 24'(comp.size()), n_wr + 24'(plain_len));
            feed(1'b0);
            settle();
        end

        // sequence cut short by the output budget, then resumed
        len = $urandom_range(2, 65);
        e = $urandom_range(1, 3);
        comp.delete();
        comp.push_back({OPC_SEQ, 6'(len - 2)});
        comp.push_back(8'(e));
        repeat (len) comp.push_back(8'($urandom));
        set_lengths(n_rd + 24'(comp.size()),
                    n_wr + 24'(len * (e + 1) - $urandom_range(1, len)));
        feed(1'b0);
        settle();
        if (ph == PH_MS_EMIT) begin
            left = int'(slen - sidx) + (int'(reps) - 1) * int'(slen);
            write_reg(REG_OUTPUT_LENGTH, n_wr + 24'(left), 1'b1);
            comp.delete();
            feed(1'b0);
            settle();
        end

        // one sticky failure to close the run
        kind = $urandom_range(FAIL_EXHAUSTED, FAIL_SHORT_SEQ);
        comp.delete();
        case (kind)
            FAIL_EXHAUSTED: begin
                comp.push_back(8'($urandom));
                set_lengths(n_rd + 24'd1, 24'hFFFFFF);
            end
            FAIL_TOO_LONG: begin
                comp.push_back({OPC_FILL, 6'd0});
                comp.push_back(8'($urandom));
                set_lengths(24'hFFFFFF, n_wr + 24'd1);
            end
            default: begin
                comp.push_back({OPC_SEQ, 6'd1});
                comp.push_back(8'h00);
                comp.push_back(8'($urandom));
                set_lengths(n_rd + 24'd3, 24'hFFFFFF);
            end
        endcase
        feed(1'b1);
        for (int i = 0; i < 5; i++) offer(1'b1, 8'($urandom), 1'b0, '0, took);
        quiet();
        settle();
        repeat (10) @(posedge i_clk);

        if (fails == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    // receiver: stretches of full rate, light and heavy stalls, one long hold
    initial begin
        int  mode;
        int  len;
        int  hold_cnt;
        bit  held;
        hold_cnt = 0;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 2);
            len = $urandom_range(20, 150);
            repeat (len) begin
                @(posedge i_clk);
                if (hold_req && !held) begin
                    held = 1'b1;
                    hold_cnt = HOLD_LEN;
                end
                if (hold_cnt > 0) begin
                    hold_cnt--;
                    m_ready <= 1'b0;
                end else if (mode == 0) begin
                    m_ready <= 1'b1;
                end else if (mode == 1) begin
                    m_ready <= ($urandom_range(0, 1) == 0);
                end else begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
            end
        end
    end

    function automatic void check_field(string name, int expv, int actv);
        if (expv != actv) begin
            $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
            fails++;
        end
    endfunction

    // compare each output word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $error("output word with nothing expected: %h", m_data);
                fails++;
            end else begin
                got = pending_words.pop_front();
                check_field("consumed", got.consumed, m_data[0]);
                check_field("out_valid", got.out_valid, m_data[1]);
                check_field("out_byte", got.out_byte, m_data[9:2]);
                check_field("finished", got.finished, m_data[10]);
                check_field("failed", got.failed, m_data[11]);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

// File: filelist.f
design/rlzd_pkg.sv
design/rlzd_ctrl.sv
design/rle_lz_byte_decompressor.sv
verif/tb_top.sv
